// ===== hw/rtl/rir_pkg.sv =====
// Package for the regret insertion repair block.
// Holds sizes, request and result types, and command and register codes.
// Depends on nothing.
`default_nettype none

package rir_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int DIST_BITS    = 16;
  localparam int MAX_RESULTS  = 64;

  localparam int VIDX_BITS  = $clog2(MAX_VERTICES);
  localparam int CNT_BITS   = $clog2(MAX_VERTICES + 1);
  localparam int DADDR_BITS = 2 * VIDX_BITS;
  localparam int DIST_DEPTH = 1 << DADDR_BITS;
  localparam int COST_BITS  = DIST_BITS + 2;
  localparam int REG_BITS   = DIST_BITS + 3;

  localparam int CMD_W    = 2;
  localparam int VERTEX_W = 6;
  localparam int DVAL_W   = 16;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_WRITE_DIST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN        = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SIZE  = 1'd1;

  localparam logic [CFG_W-1:0] NUM_VERTICES_RESET = 7'd64;
  localparam logic [CFG_W-1:0] TARGET_SIZE_RESET  = 7'd0;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [VERTEX_W-1:0] row;
    logic [VERTEX_W-1:0] col;
    logic [DVAL_W-1:0]   distance;
    logic [VERTEX_W-1:0] vertex;
  } req_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] out_vertex;
    logic [VERTEX_W-1:0] position;
    logic                last;
    logic                empty_res;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/regret_insertion_repair.sv =====
// Top level of the two-regret insertion repair block: sequencer, shared adder,
// membership bits and result register. Depends on rir_pkg and rir_ram.
//
//   channel   signals                      direction  meaning
//   request   req_valid, req_stall, req    in         load entry, append vertex, run
//   result    rsp_valid, rsp_stall, rsp    out        repaired cycle, one vertex each
//   config    cfg_write, cfg_index, cfg_data  in      vertex count, grow goal
//
// Distance writes and cycle appends may arrive every cycle.
// A run holds req_stall high until its last result is taken. Each grow step reads
// distances through the one distance read port, then shifts the cycle memory.
// Each result is read from the cycle memory, loaded into rsp and held until taken.
// Reset clears control state, the cycle length, the membership bits and the config registers;
// the memories are not cleared.
`default_nettype none

module regret_insertion_repair (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  rir_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output rir_pkg::rsp_t                  rsp,
  input  logic                           cfg_write,
  input  logic [rir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rir_pkg::CFG_W-1:0]      cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_SEED,
    ST_NEAR_RD, ST_NEAR_A, ST_NEAR_ADDR, ST_NEAR_CMP,
    ST_VTX, ST_E_RDA, ST_E_RDB, ST_E_DAV, ST_E_DVB, ST_E_DAB, ST_E_EVAL, ST_REGRET,
    ST_SHIFT, ST_SHIFT_WR,
    ST_EMIT, ST_OUT_RD, ST_OUT_LOAD, ST_OUT_WAIT
  } state_t;

  state_t state;

  logic [rir_pkg::CFG_W-1:0]             num_vertices;
  logic [rir_pkg::CFG_W-1:0]             grow_goal;
  logic [rir_pkg::CNT_BITS-1:0]          cycle_length;
  logic [rir_pkg::MAX_VERTICES-1:0]      member_flags;

  logic [rir_pkg::CNT_BITS-1:0]          vcnt;
  logic [rir_pkg::CNT_BITS-1:0]          idx;
  logic [rir_pkg::VIDX_BITS-1:0]         va;
  logic [rir_pkg::VIDX_BITS-1:0]         vb;
  logic signed [rir_pkg::COST_BITS-1:0]  acc;
  logic signed [rir_pkg::COST_BITS-1:0]  d1;
  logic signed [rir_pkg::COST_BITS-1:0]  d2;
  logic                                  h1;
  logic                                  h2;
  logic [rir_pkg::CNT_BITS-1:0]          p1;
  logic                                  found;
  logic signed [rir_pkg::REG_BITS-1:0]   breg;
  logic [rir_pkg::VIDX_BITS-1:0]         bv;
  logic [rir_pkg::CNT_BITS-1:0]          bpos;
  logic [rir_pkg::CNT_BITS-1:0]          ins_pos;
  logic [rir_pkg::VIDX_BITS-1:0]         ins_v;

  logic                                  dist_we;
  logic [rir_pkg::DADDR_BITS-1:0]        dist_waddr;
  logic [rir_pkg::DIST_BITS-1:0]         dist_wdata;
  logic [rir_pkg::DADDR_BITS-1:0]        dist_raddr;
  logic [rir_pkg::DIST_BITS-1:0]         dist_rdata;
  logic                                  cyc_we;
  logic [rir_pkg::VIDX_BITS-1:0]         cyc_waddr;
  logic [rir_pkg::VIDX_BITS-1:0]         cyc_wdata;
  logic [rir_pkg::VIDX_BITS-1:0]         cyc_raddr;
  logic [rir_pkg::VIDX_BITS-1:0]         cyc_rdata;

  logic [rir_pkg::CNT_BITS-1:0]          vcount;
  logic [rir_pkg::CNT_BITS-1:0]          idx_inc;
  logic [rir_pkg::CNT_BITS-1:0]          idx_dec;
  logic [rir_pkg::CNT_BITS-1:0]          edge_b;
  logic [rir_pkg::CNT_BITS-1:0]          emit_cnt;
  logic [rir_pkg::VIDX_BITS-1:0]         vsel;
  logic                                  can_grow;
  logic                                  req_take;
  logic                                  dist_ok;
  logic                                  append_ok;
  logic signed [rir_pkg::REG_BITS-1:0]   dist_ext;
  logic signed [rir_pkg::REG_BITS-1:0]   alu_a;
  logic signed [rir_pkg::REG_BITS-1:0]   alu_b;
  logic                                  alu_sub;
  logic signed [rir_pkg::REG_BITS-1:0]   alu_y;
  logic signed [rir_pkg::COST_BITS-1:0]  cost;
  logic                                  cost_first;
  logic                                  cost_second;

  rir_ram #(
    .WIDTH (rir_pkg::DIST_BITS),
    .DEPTH (rir_pkg::DIST_DEPTH)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  rir_ram #(
    .WIDTH (rir_pkg::VIDX_BITS),
    .DEPTH (rir_pkg::MAX_VERTICES)
  ) u_cycle_ram (
    .clk   (clk),
    .we    (cyc_we),
    .waddr (cyc_waddr),
    .wdata (cyc_wdata),
    .raddr (cyc_raddr),
    .rdata (cyc_rdata)
  );

  assign vcount = (32'(num_vertices) > rir_pkg::MAX_VERTICES) ?
                  rir_pkg::CNT_BITS'(rir_pkg::MAX_VERTICES) :
                  rir_pkg::CNT_BITS'(num_vertices);
  assign idx_inc  = idx + rir_pkg::CNT_BITS'(1);
  assign idx_dec  = idx - rir_pkg::CNT_BITS'(1);
  assign edge_b   = (idx_inc == cycle_length) ? '0 : idx_inc;
  assign emit_cnt = (32'(cycle_length) > rir_pkg::MAX_RESULTS) ?
                    rir_pkg::CNT_BITS'(rir_pkg::MAX_RESULTS) : cycle_length;
  assign vsel     = vcnt[rir_pkg::VIDX_BITS-1:0];
  assign can_grow = (32'(cycle_length) < 32'(grow_goal)) && (cycle_length < vcount) &&
                    (32'(cycle_length) < rir_pkg::MAX_VERTICES);

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && (state == ST_IDLE);
  assign dist_ok   = (32'(req.row) < rir_pkg::MAX_VERTICES) &&
                     (32'(req.col) < rir_pkg::MAX_VERTICES);
  assign append_ok = (32'(req.vertex) < 32'(vcount)) &&
                     (32'(req.vertex) < rir_pkg::MAX_VERTICES) &&
                     !member_flags[rir_pkg::VIDX_BITS'(req.vertex)] &&
                     (32'(cycle_length) < rir_pkg::MAX_VERTICES);

  // One shared add/subtract unit builds each insertion cost and each regret.
  assign dist_ext = $signed({{(rir_pkg::REG_BITS - rir_pkg::DIST_BITS){1'b0}}, dist_rdata});
  assign alu_a    = (state == ST_REGRET) ? rir_pkg::REG_BITS'(d2) : rir_pkg::REG_BITS'(acc);
  assign alu_b    = (state == ST_REGRET) ? rir_pkg::REG_BITS'(d1) : dist_ext;
  assign alu_sub  = (state != ST_E_DAB);
  assign alu_y    = alu_a + (alu_b ^ {rir_pkg::REG_BITS{alu_sub}}) +
                    rir_pkg::REG_BITS'(alu_sub);
  assign cost        = rir_pkg::COST_BITS'(alu_y);
  assign cost_first  = !h1 || (cost < d1);
  assign cost_second = !h2 || (cost < d2);

  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = {rir_pkg::VIDX_BITS'(req.row), rir_pkg::VIDX_BITS'(req.col)};
    dist_wdata = rir_pkg::DIST_BITS'(req.distance);
    dist_raddr = {va, vsel};
    cyc_we     = 1'b0;
    cyc_waddr  = cycle_length[rir_pkg::VIDX_BITS-1:0];
    cyc_wdata  = rir_pkg::VIDX_BITS'(req.vertex);
    cyc_raddr  = idx[rir_pkg::VIDX_BITS-1:0];
    case (state)
      ST_IDLE: begin
        dist_we = req_take && (req.command == rir_pkg::CMD_WRITE_DIST) && dist_ok;
        cyc_we  = req_take && (req.command == rir_pkg::CMD_APPEND) && append_ok;
      end
      ST_NEAR_RD:  cyc_raddr = '0;
      ST_E_RDB:    cyc_raddr = edge_b[rir_pkg::VIDX_BITS-1:0];
      ST_E_DVB:    dist_raddr = {vsel, vb};
      ST_E_DAB:    dist_raddr = {va, vb};
      ST_SHIFT: begin
        cyc_raddr = idx_dec[rir_pkg::VIDX_BITS-1:0];
        if (idx <= ins_pos) begin
          cyc_we    = 1'b1;
          cyc_waddr = ins_pos[rir_pkg::VIDX_BITS-1:0];
          cyc_wdata = ins_v;
        end
      end
      ST_SHIFT_WR: begin
        cyc_we    = 1'b1;
        cyc_waddr = idx[rir_pkg::VIDX_BITS-1:0];
        cyc_wdata = cyc_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      num_vertices <= rir_pkg::NUM_VERTICES_RESET;
      grow_goal    <= rir_pkg::TARGET_SIZE_RESET;
      cycle_length <= '0;
      member_flags <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rir_pkg::CFG_NUM_VERTICES: num_vertices <= cfg_data;
          rir_pkg::CFG_TARGET_SIZE:  grow_goal    <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (req_take) begin
            case (req.command)
              rir_pkg::CMD_APPEND: begin
                if (append_ok) begin
                  cycle_length <= cycle_length + rir_pkg::CNT_BITS'(1);
                  member_flags[rir_pkg::VIDX_BITS'(req.vertex)] <= 1'b1;
                end
              end
              rir_pkg::CMD_RUN: state <= ST_CHECK;
              default: begin
              end
            endcase
          end
        end

        ST_CHECK: begin
          vcnt  <= '0;
          found <= 1'b0;
          if (!can_grow) begin
            state <= ST_EMIT;
          end else if (cycle_length == '0) begin
            state <= ST_SEED;
          end else if (cycle_length == rir_pkg::CNT_BITS'(1)) begin
            state <= ST_NEAR_RD;
          end else begin
            state <= ST_VTX;
          end
        end

        ST_SEED: begin
          if (vcnt == vcount) begin
            state <= ST_EMIT;
          end else if (!member_flags[vsel]) begin
            ins_pos <= '0;
            ins_v   <= vsel;
            idx     <= cycle_length;
            state   <= ST_SHIFT;
          end else begin
            vcnt <= vcnt + rir_pkg::CNT_BITS'(1);
          end
        end

        ST_NEAR_RD: state <= ST_NEAR_A;

        ST_NEAR_A: begin
          va    <= cyc_rdata;
          state <= ST_NEAR_ADDR;
        end

        ST_NEAR_ADDR: begin
          if (vcnt == vcount) begin
            if (found) begin
              ins_pos <= rir_pkg::CNT_BITS'(1);
              ins_v   <= bv;
              idx     <= cycle_length;
              state   <= ST_SHIFT;
            end else begin
              state <= ST_EMIT;
            end
          end else if (member_flags[vsel]) begin
            vcnt <= vcnt + rir_pkg::CNT_BITS'(1);
          end else begin
            state <= ST_NEAR_CMP;
          end
        end

        ST_NEAR_CMP: begin
          if (!found || (dist_ext < breg)) begin
            found <= 1'b1;
            breg  <= dist_ext;
            bv    <= vsel;
          end
          vcnt  <= vcnt + rir_pkg::CNT_BITS'(1);
          state <= ST_NEAR_ADDR;
        end

        ST_VTX: begin
          if (vcnt == vcount) begin
            if (found) begin
              ins_pos <= bpos + rir_pkg::CNT_BITS'(1);
              ins_v   <= bv;
              idx     <= cycle_length;
              state   <= ST_SHIFT;
            end else begin
              state <= ST_EMIT;
            end
          end else if (member_flags[vsel]) begin
            vcnt <= vcnt + rir_pkg::CNT_BITS'(1);
          end else begin
            idx   <= '0;
            h1    <= 1'b0;
            h2    <= 1'b0;
            state <= ST_E_RDA;
          end
        end

        ST_E_RDA: state <= ST_E_RDB;

        ST_E_RDB: begin
          va    <= cyc_rdata;
          state <= ST_E_DAV;
        end

        ST_E_DAV: begin
          vb    <= cyc_rdata;
          state <= ST_E_DVB;
        end

        ST_E_DVB: begin
          acc   <= rir_pkg::COST_BITS'(dist_ext);
          state <= ST_E_DAB;
        end

        ST_E_DAB: begin
          acc   <= cost;
          state <= ST_E_EVAL;
        end

        ST_E_EVAL: begin
          if (cost_first) begin
            d2 <= d1;
            h2 <= h1;
            d1 <= cost;
            h1 <= 1'b1;
            p1 <= idx;
          end else if (cost_second) begin
            d2 <= cost;
            h2 <= 1'b1;
          end
          if (idx_inc == cycle_length) begin
            state <= ST_REGRET;
          end else begin
            idx   <= idx_inc;
            state <= ST_E_RDA;
          end
        end

        ST_REGRET: begin
          if (!found || (alu_y > breg)) begin
            found <= 1'b1;
            breg  <= alu_y;
            bv    <= vsel;
            bpos  <= p1;
          end
          vcnt  <= vcnt + rir_pkg::CNT_BITS'(1);
          state <= ST_VTX;
        end

        ST_SHIFT: begin
          if (idx > ins_pos) begin
            state <= ST_SHIFT_WR;
          end else begin
            cycle_length        <= cycle_length + rir_pkg::CNT_BITS'(1);
            member_flags[ins_v] <= 1'b1;
            state               <= ST_CHECK;
          end
        end

        ST_SHIFT_WR: begin
          idx   <= idx_dec;
          state <= ST_SHIFT;
        end

        ST_EMIT: begin
          idx <= '0;
          if (cycle_length == '0) begin
            rsp.out_vertex <= '0;
            rsp.position   <= '0;
            rsp.last       <= 1'b1;
            rsp.empty_res  <= 1'b1;
            rsp_valid      <= 1'b1;
            state          <= ST_OUT_WAIT;
          end else begin
            state <= ST_OUT_RD;
          end
        end

        ST_OUT_RD: state <= ST_OUT_LOAD;

        ST_OUT_LOAD: begin
          rsp.out_vertex <= rir_pkg::VERTEX_W'(cyc_rdata);
          rsp.position   <= rir_pkg::VERTEX_W'(idx);
          rsp.last       <= (idx_inc == emit_cnt);
          rsp.empty_res  <= 1'b0;
          rsp_valid      <= 1'b1;
          state          <= ST_OUT_WAIT;
        end

        ST_OUT_WAIT: begin
          if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            if (rsp.last) begin
              member_flags <= '0;
              cycle_length <= '0;
              state        <= ST_IDLE;
            end else begin
              idx   <= idx_inc;
              state <= ST_OUT_RD;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rsp_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (state == ST_OUT_WAIT))
    else $error("result valid outside the output wait state");

  a_members_match_length: assert property (@(posedge clk) disable iff (rst)
    $countones(member_flags) == 32'(cycle_length))
    else $error("membership bits disagree with the cycle length");

  a_last_clears_cycle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && rsp.last) |=> (cycle_length == '0 && !rsp_valid))
    else $error("cycle not cleared after the final result");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.empty_res) |-> rsp.last)
    else $error("empty result not marked as final");

endmodule

`default_nettype wire

// ===== hw/rtl/rir_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the distance matrix and the cycle store. No dependencies.
`default_nettype none

module rir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
